[rtl/brle_pkg.sv]
`default_nettype none

package brle_pkg;

  // Field sizes of the stream format
  localparam int unsigned MaxFieldBits = 7;
  localparam int unsigned LenW         = 3;
  localparam int unsigned DimW         = 8;
  localparam int unsigned HdrBits      = 2 * DimW + LenW;
  localparam int unsigned BodyBits     = 3 * MaxFieldBits;
  localparam int unsigned ChunkBits    = HdrBits + BodyBits;
  localparam int unsigned ChunkCntW    = $clog2(ChunkBits + 1);
  localparam int unsigned RunW         = MaxFieldBits + 1;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRunFieldBits   = 2'd0,
    CfgImageWidthM1   = 2'd1,
    CfgImageHeightM1  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic pixel;
    logic last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_stream;
  } byte_out_t;

  // Bits one pixel adds to the stream, left aligned, zeros below nbits
  typedef struct packed {
    logic [ChunkBits-1:0] bits;
    logic [ChunkCntW-1:0] nbits;
    logic                 last;
  } chunk_t;

endpackage

`default_nettype wire

[rtl/bilevel_run_length_encoder.sv]
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+------------------------------------
// cfg      | in        | cfg_we_i (no wait)   | cfg_index_i, cfg_data_i
// in       | in        | in_valid_i/in_ready_o| in_data_i  {pixel, last_pixel}
// out      | out       | out_valid_o/out_ready_i | out_data_o {out_byte, end_of_stream}
//
// One pixel transaction is taken per cycle while the chunk queue has room.
// The packer sends one byte per cycle while out_ready_i lets it; a pixel that
// yields k bytes holds the packer until they are sent (up to 5 on the first pixel of an image, with header).
// Reset clears run state, queue and packer; configuration returns to field
// size 4 and zero dimensions. Stalls on the output back up into the queue and
// only then drop in_ready_o.
`default_nettype none

module bilevel_run_length_encoder import brle_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pix_in_t             in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output byte_out_t                out_data_o
);

  chunk_t push_chunk, pop_chunk;
  logic   push, pop, q_full, q_empty;

  // Front: track the open run and turn each pixel into a chunk of stream bits
  brle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .chunk_o     (push_chunk)
  );

  // Queue: decouple pixel intake from byte bursts on the output
  brle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_chunk),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (pop_chunk),
    .empty_o (q_empty)
  );

  // Back: pack chunks MSB first into bytes, pad and mark the final byte
  brle_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .chunk_i       (pop_chunk),
    .chunk_valid_i (!q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/brle_front.sv]
`default_nettype none

module brle_front import brle_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire pix_in_t             in_data_i,
  input  wire logic                q_full_i,
  output logic                     push_o,
  output chunk_t                   chunk_o
);

  logic [LenW-1:0] cfg_len_q;
  logic [DimW-1:0] cfg_width_q, cfg_height_q;

  logic            hdr_sent_q, hdr_sent_d;
  logic            colour_q, colour_d;
  logic [MaxFieldBits-1:0] count_q, count_d;

  logic [LenW-1:0]      len;
  logic                 raw, first, pix, last, accept;
  logic [RunW-1:0]      max_run, cnt_ext, cnt_inc, sat, new_cnt;
  logic [BodyBits-1:0]  body;
  logic [ChunkCntW-1:0] blen, nbits;
  logic [ChunkBits-1:0] val;
  logic [HdrBits-1:0]   hdr;

  function automatic logic [BodyBits-1:0] append_field(
    input logic [BodyBits-1:0] acc,
    input logic [LenW-1:0]     n,
    input logic [RunW-1:0]     v
  );
    append_field = (acc << n) | BodyBits'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q    <= LenW'(4);
      cfg_width_q  <= '0;
      cfg_height_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRunFieldBits:  cfg_len_q    <= cfg_data_i[LenW-1:0];
        CfgImageWidthM1:  cfg_width_q  <= cfg_data_i[DimW-1:0];
        CfgImageHeightM1: cfg_height_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  assign pix     = in_data_i.pixel;
  assign last    = in_data_i.last_pixel;
  assign len     = (cfg_len_q > LenW'(MaxFieldBits)) ? LenW'(MaxFieldBits) : cfg_len_q;
  assign raw     = (len <= LenW'(1));
  assign first   = !hdr_sent_q;
  assign max_run = (RunW'(1) << len) - RunW'(1);
  assign cnt_ext = RunW'(count_q);
  assign cnt_inc = cnt_ext + RunW'(1);
  assign sat     = (cnt_ext > max_run) ? max_run : cnt_ext;
  assign hdr     = {cfg_width_q, cfg_height_q, len};

  always_comb begin
    body     = '0;
    blen     = '0;
    new_cnt  = cnt_ext;
    colour_d = colour_q;
    priority if (raw) begin
      body = BodyBits'(pix);
      blen = ChunkCntW'(1);
    end else if (first) begin
      if (pix) begin
        body = append_field(body, len, '0);
        blen = blen + ChunkCntW'(len);
      end
      colour_d = pix;
      new_cnt  = RunW'(1);
    end else if (pix != colour_q) begin
      body     = append_field(body, len, sat);
      blen     = blen + ChunkCntW'(len);
      colour_d = pix;
      new_cnt  = RunW'(1);
    end else begin
      new_cnt = cnt_inc;
      if (cnt_inc > max_run) begin
        // Overlong run: write the maximum, then an empty run of the other colour
        body    = append_field(body, len, max_run);
        body    = append_field(body, len, '0);
        blen    = blen + ChunkCntW'(len) + ChunkCntW'(len);
        new_cnt = RunW'(1);
      end
    end
    if (last && !raw) begin
      body = append_field(body, len, new_cnt);
      blen = blen + ChunkCntW'(len);
    end
  end

  always_comb begin
    if (first) begin
      val   = (ChunkBits'(hdr) << blen) | ChunkBits'(body);
      nbits = ChunkCntW'(HdrBits) + blen;
    end else begin
      val   = ChunkBits'(body);
      nbits = blen;
    end
  end

  assign chunk_o.bits  = val << (ChunkCntW'(ChunkBits) - nbits);
  assign chunk_o.nbits = nbits;
  assign chunk_o.last  = last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // Drop pixels that only extend the open run
  assign push_o     = accept && (nbits != '0);

  always_comb begin
    hdr_sent_d = hdr_sent_q;
    count_d    = count_q;
    if (accept) begin
      if (last) begin
        hdr_sent_d = 1'b0;
        count_d    = '0;
      end else begin
        hdr_sent_d = 1'b1;
        if (!raw) begin
          count_d = new_cnt[MaxFieldBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_sent_q <= 1'b0;
      colour_q   <= 1'b0;
      count_q    <= '0;
    end else begin
      hdr_sent_q <= hdr_sent_d;
      count_q    <= count_d;
      if (accept) begin
        colour_q <= last ? 1'b0 : (raw ? colour_q : colour_d);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/brle_queue.sv]
`default_nettype none

module brle_queue import brle_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire chunk_t data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output chunk_t      data_o,
  output logic        empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  chunk_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + CW'(1);
        2'b01:   count_q <= count_q - CW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/brle_packer.sv]
`default_nettype none

module brle_packer import brle_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire chunk_t chunk_i,
  input  wire logic   chunk_valid_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output byte_out_t   out_data_o
);

  localparam int unsigned BufBits = ChunkBits + 8;
  localparam int unsigned BufCntW = $clog2(BufBits + 1);

  logic [BufBits-1:0] buf_q, buf_d, buf_a;
  logic [BufCntW-1:0] cnt_q, cnt_d, cnt_a;
  logic               flush_q, flush_d, flush_a;
  logic               out_valid_q;
  byte_out_t          out_q;
  logic               has_byte, do_emit, take;

  assign has_byte = (cnt_q >= BufCntW'(8)) || (flush_q && (cnt_q != '0));
  assign do_emit  = has_byte && (!out_valid_q || out_ready_i);

  always_comb begin
    if (do_emit) begin
      buf_a = buf_q << 8;
      cnt_a = (cnt_q >= BufCntW'(8)) ? cnt_q - BufCntW'(8) : '0;
    end else begin
      buf_a = buf_q;
      cnt_a = cnt_q;
    end
    flush_a = flush_q && (cnt_a != '0);
    // Take a chunk once fewer than eight bits remain and no flush is open
    take    = chunk_valid_i && (cnt_a < BufCntW'(8)) && !flush_a;
    buf_d   = buf_a;
    cnt_d   = cnt_a;
    flush_d = flush_a;
    if (take) begin
      buf_d   = buf_a | ({chunk_i.bits, 8'h00} >> cnt_a);
      cnt_d   = cnt_a + BufCntW'(chunk_i.nbits);
      flush_d = flush_a || chunk_i.last;
    end
  end

  assign pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      cnt_q       <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      flush_q <= flush_d;
      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_q.out_byte      <= buf_q[BufBits-1 -: 8];
      out_q.end_of_stream <= flush_q && (cnt_q <= BufCntW'(8));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[tb/bilevel_run_length_encoder_tb.sv]
`timescale 1ns / 1ps

module bilevel_run_length_encoder_tb;
  import brle_pkg::*;

  // Keeps its own copy of the register file and of the run state. For each accepted
  // pixel it works out the bytes the stream gains and queues them for checking.
  class rle_stream_model;
    byte_out_t   pending_bytes[$];
    logic [2:0]  field_bits_reg;
    logic [7:0]  width_m1_reg;
    logic [7:0]  height_m1_reg;
    bit          header_done;
    bit          colour;
    int unsigned run_len;
    logic [7:0]  acc;
    int unsigned acc_bits;
    logic [7:0]  step_bytes[$];
    int unsigned failures;

    function new();
      field_bits_reg = 3'd4;
      width_m1_reg   = '0;
      height_m1_reg  = '0;
      failures       = 0;
      clear_image();
    endfunction

    function void clear_image();
      header_done = 1'b0;
      colour      = 1'b0;
      run_len     = 0;
      acc         = '0;
      acc_bits    = 0;
    endfunction

    function void set_reg(cfg_index_e idx, logic [7:0] data);
      case (idx)
        CfgRunFieldBits:  field_bits_reg = data[2:0];
        CfgImageWidthM1:  width_m1_reg = data;
        CfgImageHeightM1: height_m1_reg = data;
        default: ;
      endcase
    endfunction

    // Append n bits, MSB first, and emit every byte that completes.
    function void shift_bits(int unsigned value, int unsigned n);
      for (int i = int'(n) - 1; i >= 0; i--) begin
        acc = {acc[6:0], value[i]};
        acc_bits++;
        if (acc_bits == 8) begin
          step_bytes.push_back(acc);
          acc      = '0;
          acc_bits = 0;
        end
      end
    endfunction

    function void note_pixel(pix_in_t px);
      int unsigned len;
      int unsigned maxrun;
      int unsigned n_out;
      bit          raw;
      bit          first;
      logic [7:0]  tail;
      byte_out_t   b;
      len    = (field_bits_reg > MaxFieldBits) ? MaxFieldBits : field_bits_reg;
      raw    = (len <= 1);
      maxrun = (1 << len) - 1;
      step_bytes.delete();
      first  = !header_done;
      if (first) begin
        shift_bits(width_m1_reg, DimW);
        shift_bits(height_m1_reg, DimW);
        shift_bits(len, LenW);
        header_done = 1'b1;
      end
      if (raw) begin
        shift_bits(px.pixel, 1);
      end else if (first) begin
        // A lit first pixel opens with an empty run of colour 0.
        if (px.pixel) shift_bits(0, len);
        colour  = px.pixel;
        run_len = 1;
      end else if (px.pixel != colour) begin
        shift_bits((run_len > maxrun) ? maxrun : run_len, len);
        colour  = px.pixel;
        run_len = 1;
      end else begin
        run_len = (run_len + 1) & 8'hFF;
        // Split an overlong run: full field, then an empty run of the other colour.
        if (run_len > maxrun) begin
          shift_bits(maxrun, len);
          shift_bits(0, len);
          run_len = 1;
        end
      end
      if (px.last_pixel) begin
        if (!raw) shift_bits((run_len > maxrun) ? maxrun : run_len, len);
        if (acc_bits > 0) begin
          tail = acc << (8 - acc_bits);
          step_bytes.push_back(tail);
        end
        clear_image();
      end
      n_out = (step_bytes.size() > 5) ? 5 : step_bytes.size();
      for (int k = 0; k < int'(n_out); k++) begin
        b.out_byte      = step_bytes[k];
        b.end_of_stream = px.last_pixel && (k == int'(n_out) - 1);
        pending_bytes.push_back(b);
      end
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_byte(byte_out_t got);
      byte_out_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h end_of_stream %0b",
                         got.out_byte, got.end_of_stream));
        return;
      end
      want = pending_bytes.pop_front();
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte expected %02h got %02h", want.out_byte, got.out_byte));
      if (got.end_of_stream !== want.end_of_stream)
        report($sformatf("end_of_stream expected %0b got %0b (byte %02h)",
                         want.end_of_stream, got.end_of_stream, want.out_byte));
    endfunction
  endclass

  // Longest stretch with no transaction on either channel before the run is called hung.
  localparam int unsigned StallLimit    = 2000;
  // Receiver hold-off long enough to fill the internal queue and back up the input.
  localparam int unsigned HoldOffCycles = 150;
  // Cycles to let pixels that emit nothing work through the queue before a register write.
  localparam int unsigned SettleCycles  = 40;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  cfg_index_e          cfg_index_i = CfgRunFieldBits;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  pix_in_t             in_data_i   = '0;
  logic                out_ready_i = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  byte_out_t           out_data_o;

  rle_stream_model stream_model;

  // Sender burst shaping and the pixel generator's state.
  int unsigned burst_left   = 0;
  bit          gaps_enabled = 1'b1;
  bit          cur_colour   = 1'b0;
  int unsigned run_left     = 0;
  int unsigned image_left   = 0;

  // Hold-off requests from the stimulus, served by the receiver process.
  int unsigned hold_off_asked  = 0;
  int unsigned hold_off_served = 0;
  int unsigned idle_cycles     = 0;

  bilevel_run_length_encoder u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one pixel and hold it until the transaction completes. Valid is never
  // dropped between back-to-back pixels; gaps fall only at burst boundaries.
  task automatic offer_pixel(input bit pixel, input bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      if (gaps_enabled) begin
        gap = $urandom_range(1, 8);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel: pixel, last_pixel: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Write all three registers, one per cycle; the model follows at once since
  // no pixel is in flight.
  task automatic load_config(input logic [7:0] field_bits, input logic [7:0] width_m1,
                             input logic [7:0] height_m1);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgRunFieldBits;
    cfg_data_i  <= field_bits;
    stream_model.set_reg(CfgRunFieldBits, field_bits);
    @(posedge clk_i);
    cfg_index_i <= CfgImageWidthM1;
    cfg_data_i  <= width_m1;
    stream_model.set_reg(CfgImageWidthM1, width_m1);
    @(posedge clk_i);
    cfg_index_i <= CfgImageHeightM1;
    cfg_data_i  <= height_m1;
    stream_model.set_reg(CfgImageHeightM1, height_m1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering, wait for every queued byte, then let silent pixels settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (stream_model.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random images built from runs. Run lengths favor the field's limit so that
  // overlong runs get split; images span phases, so registers also change mid-image.
  task automatic send_random(input int unsigned count);
    int unsigned maxrun;
    int unsigned pick;
    bit          last;
    repeat (count) begin
      maxrun = (1 << stream_model.field_bits_reg) - 1;
      if (image_left == 0) begin
        image_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
        cur_colour = 1'($urandom_range(0, 1));
        run_left   = 0;
      end else if (run_left == 0) begin
        cur_colour = !cur_colour;
      end
      if (run_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 6)      run_left = $urandom_range(1, 3);
        else if (pick < 8) run_left = $urandom_range(1, 40);
        else               run_left = (maxrun < 40) ? maxrun + $urandom_range(0, 1)
                                                    : $urandom_range(1, 40);
        if (run_left == 0) run_left = 1;
      end
      last = (image_left == 1);
      offer_pixel(cur_colour, last);
      image_left--;
      run_left--;
    end
  endtask

  // Receiver: stall in spans of random style, or hold off entirely on request.
  // A pending hold-off request cuts the current span short.
  initial begin : receiver
    int unsigned style;
    int unsigned span;
    forever begin
      if (hold_off_served != hold_off_asked) begin
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_served++;
      end else begin
        style = $urandom_range(0, 3);
        span  = $urandom_range(8, 60);
        for (int k = 0; k < int'(span); k++) begin
          if (hold_off_served != hold_off_asked) break;
          case (style)
            0:       out_ready_i <= 1'b1;
            1:       out_ready_i <= ($urandom_range(0, 1) == 1);
            2:       out_ready_i <= (k % 4 != 3);
            default: out_ready_i <= ($urandom_range(0, 7) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Monitor both channels on the edge that completes each transaction, and watch
  // for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) stream_model.note_pixel(in_data_i);
      if (out_valid_o && out_ready_i) stream_model.check_byte(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("bilevel_run_length_encoder regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [2:0] field_plan [8];
    field_plan = '{3'd2, 3'd7, 3'd1, 3'd3, 3'd5, 3'd0, 3'd6, 3'd4};
    stream_model = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Lone lit pixel at the widest field and full dimensions: header, empty
    // leading run and the closing run give the most bytes one pixel can cause.
    load_config(8'd7, 8'd255, 8'd255);
    offer_pixel(1'b1, 1'b1);
    wait_drained();

    // Field size zero copies pixels raw, the same as size one.
    load_config(8'd0, 8'd0, 8'd0);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b0, 1'b0);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b1, 1'b1);
    wait_drained();

    // Narrowest run field: a run of five gets split.
    load_config(8'd2, 8'hA5, 8'h5A);
    repeat (5) offer_pixel(1'b0, 1'b0);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b1, 1'b1);
    wait_drained();

    // Shrink the field mid-image while a run is longer than the new limit.
    load_config(8'd5, 8'h5A, 8'hA5);
    repeat (6) offer_pixel(1'b0, 1'b0);
    wait_drained();
    load_config(8'd2, 8'h5A, 8'hA5);
    offer_pixel(1'b0, 1'b0);
    offer_pixel(1'b1, 1'b1);
    wait_drained();

    // Start raw, then switch to runs mid-image with no run open.
    load_config(8'd1, 8'hFF, 8'h00);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b1, 1'b0);
    wait_drained();
    load_config(8'd3, 8'h00, 8'hFF);
    offer_pixel(1'b1, 1'b0);
    offer_pixel(1'b1, 1'b1);
    wait_drained();

    // Random phases, one register setting each, draining in between.
    foreach (field_plan[i]) begin
      load_config({5'd0, field_plan[i]}, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      send_random($urandom_range(12, 20));
      wait_drained();
    end

    // Back-pressure: block the receiver and keep offering alternating pixels with
    // no gaps, so every pixel after the first adds a run field, the queue fills and
    // the input stalls; then drain fully.
    load_config(8'd2, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    hold_off_asked++;
    gaps_enabled = 1'b0;
    for (int i = 0; i < 32; i++) offer_pixel(i[0], i == 31);
    gaps_enabled = 1'b1;
    wait_drained();

    if (stream_model.failures == 0 && stream_model.pending_bytes.size() == 0) begin
      $display("bilevel_run_length_encoder regression: pass");
    end else begin
      $display("bilevel_run_length_encoder regression: fail");
    end
    $finish;
  end

endmodule
